FILE: hdl/framed_packet_receiver_defines.svh
// Assertion macros shared by the framed packet receiver RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define FRAMED_PACKET_RECEIVER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fpr_pkg.sv
// Package for the framed packet receiver: phase and event codes, config indexes,
// config and result structs. No dependencies.
package fpr_pkg;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned EventW = 3;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PhaseW-1:0] PH_HUNT1 = 4'd0;
  localparam logic [PhaseW-1:0] PH_HUNT2 = 4'd1;
  localparam logic [PhaseW-1:0] PH_ID    = 4'd2;
  localparam logic [PhaseW-1:0] PH_LENLO = 4'd3;
  localparam logic [PhaseW-1:0] PH_LENHI = 4'd4;
  localparam logic [PhaseW-1:0] PH_CMD   = 4'd5;
  localparam logic [PhaseW-1:0] PH_DATA  = 4'd6;
  localparam logic [PhaseW-1:0] PH_SUMLO = 4'd7;
  localparam logic [PhaseW-1:0] PH_SUMHI = 4'd8;
  localparam logic [PhaseW-1:0] PH_END1  = 4'd9;
  localparam logic [PhaseW-1:0] PH_END2  = 4'd10;

  localparam logic [EventW-1:0] EV_NONE = 3'd0;
  localparam logic [EventW-1:0] EV_DATA = 3'd1;
  localparam logic [EventW-1:0] EV_GOOD = 3'd2;
  localparam logic [EventW-1:0] EV_BAD  = 3'd3;
  localparam logic [EventW-1:0] EV_WAKE = 3'd4;

  localparam logic [CfgIdxW-1:0] CFG_START_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_FIRST    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_END_SECOND   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WAKE_BYTE    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WAKE_LIMIT   = 3'd5;

  localparam logic [7:0] RST_START_FIRST  = 8'hAB;
  localparam logic [7:0] RST_START_SECOND = 8'hCD;
  localparam logic [7:0] RST_END_FIRST    = 8'h0A;
  localparam logic [7:0] RST_END_SECOND   = 8'h0D;
  localparam logic [7:0] RST_WAKE_BYTE    = 8'h80;
  localparam logic [7:0] RST_WAKE_LIMIT   = 8'd5;

  localparam logic [15:0] HDR_LEN = 16'd3;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [7:0] end_first;
    logic [7:0] end_second;
    logic [7:0] wake_byte;
    logic [7:0] wake_limit;
  } fpr_cfg_t;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [7:0]        payload_value;
    logic [15:0]       payload_index;
    logic [7:0]        packet_id;
    logic [7:0]        command;
    logic [15:0]       payload_length;
  } fpr_res_t;

endpackage

FILE: hdl/fpr_cfg_regs.sv
// Configuration register file for the framed packet receiver.
// Depends on fpr_pkg.
module fpr_cfg_regs
  import fpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [7:0]         wr_data,
  output fpr_cfg_t           cfg
);

  fpr_cfg_t cfg_r;
  fpr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_START_FIRST:  cfg_nxt.start_first  = wr_data;
        CFG_START_SECOND: cfg_nxt.start_second = wr_data;
        CFG_END_FIRST:    cfg_nxt.end_first    = wr_data;
        CFG_END_SECOND:   cfg_nxt.end_second   = wr_data;
        CFG_WAKE_BYTE:    cfg_nxt.wake_byte    = wr_data;
        CFG_WAKE_LIMIT:   cfg_nxt.wake_limit   = wr_data;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_first  <= RST_START_FIRST;
      cfg_r.start_second <= RST_START_SECOND;
      cfg_r.end_first    <= RST_END_FIRST;
      cfg_r.end_second   <= RST_END_SECOND;
      cfg_r.wake_byte    <= RST_WAKE_BYTE;
      cfg_r.wake_limit   <= RST_WAKE_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/fpr_parser.sv
// Frame parser: phase state machine, header/sum/count registers and the
// per-byte result logic. Depends on fpr_pkg.
module fpr_parser
  import fpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  fpr_cfg_t   cfg,
  output fpr_res_t   res
);

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [7:0]        len_lo_r, len_lo_nxt;
  logic [15:0]       body_len_r, body_len_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [15:0]       count_r, count_nxt;
  logic [7:0]        probe_r, probe_nxt;

  logic [15:0]       sum_add;
  logic [15:0]       count_inc;
  logic [15:0]       len_full;
  logic [EventW-1:0] ev;
  logic              frame_ev;

  assign sum_add   = sum_r + {8'd0, rx_byte};
  assign count_inc = count_r + 16'd1;
  assign len_full  = {rx_byte, len_lo_r};

  always_comb begin
    phase_nxt    = phase_r;
    id_nxt       = id_r;
    len_lo_nxt   = len_lo_r;
    body_len_nxt = body_len_r;
    cmd_nxt      = cmd_r;
    sum_nxt      = sum_r;
    count_nxt    = count_r;
    probe_nxt    = probe_r;
    ev           = EV_NONE;
    unique case (phase_r)
      PH_HUNT1: begin
        if (rx_byte == cfg.start_first) begin
          probe_nxt = 8'd0;
          phase_nxt = PH_HUNT2;
        end else if (rx_byte == cfg.wake_byte) begin
          if (probe_r > cfg.wake_limit) begin
            ev = EV_WAKE;
          end
          if (probe_r != 8'hFF) begin
            probe_nxt = probe_r + 8'd1;
          end
        end
      end
      PH_HUNT2: begin
        phase_nxt = (rx_byte == cfg.start_second) ? PH_ID : PH_HUNT1;
      end
      PH_ID: begin
        id_nxt    = rx_byte;
        sum_nxt   = {8'd0, rx_byte};
        count_nxt = 16'd0;
        phase_nxt = PH_LENLO;
      end
      PH_LENLO: begin
        len_lo_nxt = rx_byte;
        sum_nxt    = sum_add;
        phase_nxt  = PH_LENHI;
      end
      PH_LENHI: begin
        body_len_nxt = (len_full > HDR_LEN) ? (len_full - HDR_LEN) : 16'd0;
        sum_nxt      = sum_add;
        phase_nxt    = PH_CMD;
      end
      PH_CMD: begin
        cmd_nxt   = rx_byte;
        sum_nxt   = sum_add;
        count_nxt = 16'd0;
        phase_nxt = (body_len_r != 16'd0) ? PH_DATA : PH_SUMLO;
      end
      PH_DATA: begin
        ev        = EV_DATA;
        sum_nxt   = sum_add;
        count_nxt = count_inc;
        if (count_inc >= body_len_r) begin
          phase_nxt = PH_SUMLO;
        end
      end
      PH_SUMLO: begin
        if (rx_byte == sum_r[7:0]) begin
          phase_nxt = PH_SUMHI;
        end else begin
          ev        = EV_BAD;
          phase_nxt = PH_HUNT1;
        end
      end
      PH_SUMHI: begin
        if (rx_byte == sum_r[15:8]) begin
          phase_nxt = PH_END1;
        end else begin
          ev        = EV_BAD;
          phase_nxt = PH_HUNT1;
        end
      end
      PH_END1: begin
        if (rx_byte == cfg.end_first) begin
          phase_nxt = PH_END2;
        end else begin
          ev        = EV_BAD;
          phase_nxt = PH_HUNT1;
        end
      end
      PH_END2: begin
        ev        = (rx_byte == cfg.end_second) ? EV_GOOD : EV_BAD;
        phase_nxt = PH_HUNT1;
      end
      default: begin
        phase_nxt = PH_HUNT1;
      end
    endcase
  end

  assign frame_ev = (ev == EV_DATA) || (ev == EV_GOOD) || (ev == EV_BAD);

  always_comb begin
    res.event_res      = ev;
    res.payload_value  = (ev == EV_DATA) ? rx_byte : 8'd0;
    res.payload_index  = (ev == EV_DATA) ? count_r : 16'd0;
    res.packet_id      = frame_ev ? id_r : 8'd0;
    res.command        = frame_ev ? cmd_r : 8'd0;
    res.payload_length = frame_ev ? body_len_r : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT1;
      id_r       <= 8'd0;
      len_lo_r   <= 8'd0;
      body_len_r <= 16'd0;
      cmd_r      <= 8'd0;
      sum_r      <= 16'd0;
      count_r    <= 16'd0;
      probe_r    <= 8'd0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      id_r       <= id_nxt;
      len_lo_r   <= len_lo_nxt;
      body_len_r <= body_len_nxt;
      cmd_r      <= cmd_nxt;
      sum_r      <= sum_nxt;
      count_r    <= count_nxt;
      probe_r    <= probe_nxt;
    end
  end

endmodule

FILE: hdl/framed_packet_receiver.sv
// Framed packet receiver, top level: input register, parser, result register.
// Depends on fpr_pkg, fpr_cfg_regs, fpr_parser, framed_packet_receiver_defines.svh.
//
// Takes one received byte per transfer and returns exactly one result per byte
// (event none, payload byte, frame good, frame bad or wake request), in order.
// Throughput is one byte per clock while the output is not stalled. A byte's result
// is presented on out_valid after the byte has passed the input register, the
// combinational parser step and the result register. Both sides may stall freely.
// Config writes are taken every cycle (cfg_ready is always high) and must only be
// issued while idle; indexes 6 and 7 are ignored. Config resets to start 0xAB 0xCD,
// end 0x0A 0x0D, wake byte 0x80, wake limit 5.
`include "framed_packet_receiver_defines.svh"

module framed_packet_receiver
  import fpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [EventW-1:0]  out_event_res,
  output logic [7:0]         out_payload_value,
  output logic [15:0]        out_payload_index,
  output logic [7:0]         out_packet_id,
  output logic [7:0]         out_command,
  output logic [15:0]        out_payload_length,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data
);

  fpr_cfg_t cfg;
  fpr_res_t res;
  fpr_res_t res_r;

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  logic       adv;

  assign cfg_ready = 1'b1;

  fpr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
  end

  fpr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_event_res      = res_r.event_res;
  assign out_payload_value  = res_r.payload_value;
  assign out_payload_index  = res_r.payload_index;
  assign out_packet_id      = res_r.packet_id;
  assign out_command        = res_r.command;
  assign out_payload_length = res_r.payload_length;

  `FPR_ASSERT_IMP(a_no_frame_fields, out_vld_r && (res_r.event_res == EV_NONE || res_r.event_res == EV_WAKE), res_r.packet_id == 8'd0 && res_r.command == 8'd0 && res_r.payload_length == 16'd0, "frame fields set on non-frame event")
  `FPR_ASSERT_IMP(a_no_payload_fields, out_vld_r && res_r.event_res != EV_DATA, res_r.payload_value == 8'd0 && res_r.payload_index == 16'd0, "payload fields set on non-data event")
  `FPR_ASSERT_NXT(a_in_reg_holds, in_vld_r && !adv, in_vld_r && $stable(in_byte_r), "input register lost a stalled byte")

endmodule
